>>> hdl/assert_macros.svh
// Assertion helpers used by the bit packer (dtbe_bit_packer.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, ck, rn, ante, cons)
`define ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

>>> hdl/dtbe_pkg.sv
`timescale 1ns / 1ps

package dtbe_pkg;

    localparam int LITLEN_SYMBOLS = 286;
    localparam int DIST_SYMBOLS   = 30;
    localparam int MAX_CODE_LEN   = 15;
    localparam int ENTRY_W        = 19;
    localparam int ACC_W          = 56;

    localparam logic [2:0] CMD_LOAD_LITLEN = 3'd0;
    localparam logic [2:0] CMD_LOAD_DIST   = 3'd1;
    localparam logic [2:0] CMD_LITERAL     = 3'd2;
    localparam logic [2:0] CMD_MATCH       = 3'd3;
    localparam logic [2:0] CMD_FINISH      = 3'd4;

    localparam logic [8:0] END_SYMBOL = 9'd256;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [8:0]  table_index;
        logic [14:0] code_bits;
        logic [3:0]  code_len;
        logic [7:0]  literal;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef struct packed {
        logic               lit_we;
        logic               dist_we;
        logic [8:0]         idx;
        logic [ENTRY_W-1:0] entry;
    } tbl_wr_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] lit_entry;
        logic [4:0]         lit_xv;
        logic [2:0]         lit_nx;
        logic [ENTRY_W-1:0] dist_entry;
        logic [12:0]        dist_xv;
        logic [3:0]         dist_nx;
        logic               fin;
    } pack_req_t;

    typedef struct packed {
        logic [8:0] sym;
        logic [2:0] nx;
        logic [4:0] xv;
    } len_map_t;

    typedef struct packed {
        logic [4:0]  sym;
        logic [3:0]  nx;
        logic [12:0] xv;
    } dist_map_t;

    function automatic logic [ENTRY_W-1:0] make_entry(logic [14:0] bits, logic [3:0] len);
        logic [3:0]  l;
        logic [14:0] b;
        l = (len > 4'(MAX_CODE_LEN)) ? 4'(MAX_CODE_LEN) : len;
        for (int i = 0; i < 15; i++)
        begin
            b[i] = bits[i] & (4'(i) < l);
        end
        return {l, b};
    endfunction

    function automatic len_map_t map_length(logic [8:0] len);
        len_map_t   r;
        logic [8:0] m;
        logic [8:0] t;
        m = len;
        if (m < 9'd3)
        begin
            m = 9'd3;
        end
        if (m > 9'd258)
        begin
            m = 9'd258;
        end
        t = '0;
        r = '0;
        if (m <= 9'd10)
        begin
            r.sym = m + 9'd254;
        end
        else if (m <= 9'd18)
        begin
            t = m - 9'd11;
            r.nx = 3'd1;
            r.sym = 9'd265 + (t >> 1);
            r.xv = {4'd0, t[0]};
        end
        else if (m <= 9'd34)
        begin
            t = m - 9'd19;
            r.nx = 3'd2;
            r.sym = 9'd269 + (t >> 2);
            r.xv = {3'd0, t[1:0]};
        end
        else if (m <= 9'd66)
        begin
            t = m - 9'd35;
            r.nx = 3'd3;
            r.sym = 9'd273 + (t >> 3);
            r.xv = {2'd0, t[2:0]};
        end
        else if (m <= 9'd130)
        begin
            t = m - 9'd67;
            r.nx = 3'd4;
            r.sym = 9'd277 + (t >> 4);
            r.xv = {1'd0, t[3:0]};
        end
        else if (m <= 9'd257)
        begin
            t = m - 9'd131;
            r.nx = 3'd5;
            r.sym = 9'd281 + (t >> 5);
            r.xv = t[4:0];
        end
        else
        begin
            r.sym = 9'd285;
        end
        return r;
    endfunction

    function automatic dist_map_t map_distance(logic [15:0] distance);
        dist_map_t   r;
        logic [15:0] s;
        logic [14:0] d;
        logic [12:0] t;
        logic [3:0]  msb;
        s = distance;
        if (s == 16'd0)
        begin
            s = 16'd1;
        end
        if (s > 16'd32768)
        begin
            s = 16'd32768;
        end
        d = 15'(s - 16'd1);
        t = d[14:2];
        msb = '0;
        r = '0;
        for (int i = 0; i < 13; i++)
        begin
            if (t[i])
            begin
                msb = 4'(i + 1);
            end
        end
        if (d < 15'd4)
        begin
            r.sym = d[4:0];
        end
        else
        begin
            r.nx = msb;
            r.sym = {msb, 1'b0} + 5'd2 + {4'd0, d[msb]};
            for (int i = 0; i < 13; i++)
            begin
                r.xv[i] = d[i] & (4'(i) < msb);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/deflate_token_bit_encoder_unit.sv
`timescale 1ns / 1ps
// A token's first byte passes the input register, the table read register and the packer
// register, in that order, before it is offered.
// Loads and dropped commands never wait on the packer; a literal, match or finish moves on
// only once the packer register has sent its pending bytes, one byte per output beat.
// Reset clears the pipeline valids and the pending bits; code tables hold junk until loaded.

module deflate_token_bit_encoder_unit
    import dtbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    output logic    tok_stall,
    input  token_t  tok,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    token_t      tok_reg;
    logic        a_vld_reg;
    logic        a_vld_next;
    logic        b_vld_reg;
    logic        b_vld_next;
    logic        b_match_reg;
    logic        b_fin_reg;
    logic [4:0]  b_lxv_reg;
    logic [2:0]  b_lnx_reg;
    logic [12:0] b_dxv_reg;
    logic [3:0]  b_dnx_reg;

    logic        a_emits;
    logic        a_done;
    logic        b_load;
    logic        b_adv;
    logic        accept;
    logic        pack_free;
    len_map_t    lmap;
    dist_map_t   dmap;
    logic [8:0]  lit_addr;
    tbl_wr_t     wr;
    pack_req_t   req;
    logic [ENTRY_W-1:0] lit_data;
    logic [ENTRY_W-1:0] dist_data;

    assign a_emits = (tok_reg.cmd == CMD_LITERAL) || (tok_reg.cmd == CMD_MATCH) ||
                     (tok_reg.cmd == CMD_FINISH);
    assign b_adv     = b_vld_reg && pack_free;
    assign a_done    = a_vld_reg && (!a_emits || !b_vld_reg || b_adv);
    assign b_load    = a_done && a_emits;
    assign tok_stall = a_vld_reg && !a_done;
    assign accept    = tok_valid && !tok_stall;

    assign lmap = map_length(tok_reg.match_length);
    assign dmap = map_distance(tok_reg.match_distance);

    always_comb
    begin
        case (tok_reg.cmd)
            CMD_LITERAL: lit_addr = {1'b0, tok_reg.literal};
            CMD_MATCH:   lit_addr = lmap.sym;
            default:     lit_addr = END_SYMBOL;
        endcase
    end

    always_comb
    begin
        wr.lit_we  = a_vld_reg && (tok_reg.cmd == CMD_LOAD_LITLEN);
        wr.dist_we = a_vld_reg && (tok_reg.cmd == CMD_LOAD_DIST);
        wr.idx     = tok_reg.table_index;
        wr.entry   = make_entry(tok_reg.code_bits, tok_reg.code_len);
    end

    assign a_vld_next = accept ? 1'b1 : (a_done ? 1'b0 : a_vld_reg);
    assign b_vld_next = b_load ? 1'b1 : (b_adv ? 1'b0 : b_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok;
        end
        if (b_load)
        begin
            b_match_reg <= (tok_reg.cmd == CMD_MATCH);
            b_fin_reg   <= (tok_reg.cmd == CMD_FINISH);
            b_lxv_reg   <= (tok_reg.cmd == CMD_MATCH) ? lmap.xv : '0;
            b_lnx_reg   <= (tok_reg.cmd == CMD_MATCH) ? lmap.nx : '0;
            b_dxv_reg   <= (tok_reg.cmd == CMD_MATCH) ? dmap.xv : '0;
            b_dnx_reg   <= (tok_reg.cmd == CMD_MATCH) ? dmap.nx : '0;
        end
    end

    dtbe_code_tables u_tables (
        .clk       (clk),
        .wr        (wr),
        .rd_en     (b_load),
        .lit_addr  (lit_addr),
        .dist_addr (dmap.sym),
        .lit_data  (lit_data),
        .dist_data (dist_data)
    );

    always_comb
    begin
        req.lit_entry  = lit_data;
        req.lit_xv     = b_lxv_reg;
        req.lit_nx     = b_lnx_reg;
        req.dist_entry = b_match_reg ? dist_data : '0;
        req.dist_xv    = b_dxv_reg;
        req.dist_nx    = b_dnx_reg;
        req.fin        = b_fin_reg;
    end

    dtbe_bit_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (b_vld_reg),
        .req       (req),
        .free      (pack_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

>>> hdl/dtbe_code_tables.sv
`timescale 1ns / 1ps

module dtbe_code_tables
    import dtbe_pkg::*;
(
    input  logic               clk,
    input  tbl_wr_t            wr,
    input  logic               rd_en,
    input  logic [8:0]         lit_addr,
    input  logic [4:0]         dist_addr,
    output logic [ENTRY_W-1:0] lit_data,
    output logic [ENTRY_W-1:0] dist_data
);

    logic [ENTRY_W-1:0] lit_mem [LITLEN_SYMBOLS];
    logic [ENTRY_W-1:0] dist_mem [DIST_SYMBOLS];
    logic [ENTRY_W-1:0] lit_data_reg;
    logic [ENTRY_W-1:0] dist_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.lit_we && (wr.idx < 9'(LITLEN_SYMBOLS)))
        begin
            lit_mem[wr.idx] <= wr.entry;
        end
        if (wr.dist_we && (wr.idx < 9'(DIST_SYMBOLS)))
        begin
            dist_mem[wr.idx[4:0]] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lit_data_reg  <= lit_mem[lit_addr];
            dist_data_reg <= dist_mem[dist_addr];
        end
    end

    assign lit_data  = lit_data_reg;
    assign dist_data = dist_data_reg;

endmodule

>>> hdl/dtbe_bit_packer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtbe_bit_packer
    import dtbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  pack_req_t req,
    output logic      free,
    output logic      res_valid,
    input  logic      res_stall,
    output result_t   res
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [5:0]       cnt_reg;
    logic [5:0]       cnt_next;
    logic             fin_reg;
    logic             fin_next;

    logic [3:0]  len1;
    logic [3:0]  len2;
    logic [19:0] piece_a;
    logic [27:0] piece_b;
    logic [4:0]  len_a;
    logic [4:0]  len_b;
    logic [47:0] word;
    logic [5:0]  total;
    logic [6:0]  leftover;
    logic [ACC_W-1:0] merged;
    logic        load;
    logic        beat;

    assign res_valid = (cnt_reg >= 6'd8) || (fin_reg && (cnt_reg != 6'd0));
    assign free      = !res_valid;
    assign load      = req_valid && free;
    assign beat      = res_valid && !res_stall;

    assign res.out_byte = acc_reg[7:0];
    assign res.last     = fin_reg && (cnt_reg <= 6'd8);

    always_comb
    begin
        len1     = req.lit_entry[18:15];
        len2     = req.dist_entry[18:15];
        piece_a  = {5'd0, req.lit_entry[14:0]} | (20'(req.lit_xv) << len1);
        len_a    = 5'(len1) + 5'(req.lit_nx);
        piece_b  = {13'd0, req.dist_entry[14:0]} | (28'(req.dist_xv) << len2);
        len_b    = 5'(len2) + 5'(req.dist_nx);
        word     = 48'(piece_a) | (48'(piece_b) << len_a);
        total    = 6'(len_a) + 6'(len_b);
        leftover = acc_reg[6:0] & 7'((8'd1 << cnt_reg[2:0]) - 8'd1);
        merged   = ACC_W'(leftover) | (ACC_W'(word) << cnt_reg[2:0]);

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        if (load)
        begin
            acc_next = merged;
            cnt_next = total + {3'd0, cnt_reg[2:0]};
            fin_next = req.fin;
        end
        else if (beat)
        begin
            acc_next = acc_reg >> 8;
            cnt_next = (cnt_reg <= 6'd8) ? 6'd0 : (cnt_reg - 6'd8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    `ASSERT_IMP(a_load_when_drained, clk, rst_n, load, cnt_reg < 6'd8)
    `ASSERT_NXT(a_last_empties, clk, rst_n, beat && res.last, cnt_reg == 6'd0)
    `ASSERT_NXT(a_beat_drops_byte, clk, rst_n, beat && !res.last,
                cnt_reg == ($past(cnt_reg) - 6'd8))

endmodule
